/* rtl/line_segment_window_clipper_macros.svh */
// ---------------------------------------------------------------------------
// line_segment_window_clipper assertion macros
// shared assertion forms for the clipper's checks
// ---------------------------------------------------------------------------
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_MACROS_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSWC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LSWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lswc_pkg.sv */
// ---------------------------------------------------------------------------
// lswc_pkg
// types, codes and the case decision function of the segment clipper
// ---------------------------------------------------------------------------
package lswc_pkg;

  localparam int COORD_W  = 32;
  // quotient bits resolved in each divider stage
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = COORD_W / DIV_BITS;

  // configuration register indexes
  localparam logic [1:0] CFG_X_MIN = 2'd0;
  localparam logic [1:0] CFG_Y_MIN = 2'd1;
  localparam logic [1:0] CFG_X_MAX = 2'd2;
  localparam logic [1:0] CFG_Y_MAX = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } window_t;

  // edge operations applied by one cut step
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE    = 3'd0;
  localparam op_t OP_A_LEFT  = 3'd1;
  localparam op_t OP_A_TOP   = 3'd2;
  localparam op_t OP_A_BOT   = 3'd3;
  localparam op_t OP_B_RIGHT = 3'd4;
  localparam op_t OP_B_TOP   = 3'd5;
  localparam op_t OP_B_BOT   = 3'd6;
  localparam op_t OP_REJECT  = 3'd7;

  // region bits
  localparam logic [3:0] RG_LEFT   = 4'b0001;
  localparam logic [3:0] RG_RIGHT  = 4'b0010;
  localparam logic [3:0] RG_BOTTOM = 4'b0100;
  localparam logic [3:0] RG_TOP    = 4'b1000;

  // region codes that appear in the case table
  localparam logic [3:0] RC_IN = 4'b0000;
  localparam logic [3:0] RC_L  = RG_LEFT;
  localparam logic [3:0] RC_R  = RG_RIGHT;
  localparam logic [3:0] RC_B  = RG_BOTTOM;
  localparam logic [3:0] RC_T  = RG_TOP;
  localparam logic [3:0] RC_LB = RG_LEFT | RG_BOTTOM;
  localparam logic [3:0] RC_RB = RG_RIGHT | RG_BOTTOM;
  localparam logic [3:0] RC_LT = RG_LEFT | RG_TOP;
  localparam logic [3:0] RC_RT = RG_RIGHT | RG_TOP;

  // bits of the applied-operation mask
  localparam int DN_AL = 0;
  localparam int DN_AT = 1;
  localparam int DN_AB = 2;
  localparam int DN_BR = 3;
  localparam int DN_BT = 4;
  localparam int DN_BB = 5;
  localparam int DN_W  = 6;

  // one segment in flight
  typedef struct packed {
    point_t          a;
    point_t          b;
    logic [7:0]      case_code;
    logic [DN_W-1:0] done;
    logic            rej;
  } seg_t;

  function automatic logic [3:0] region_code(input point_t p, input window_t w);
    logic [3:0] c;
    c = RC_IN;
    if (p.x < w.x_min) c = c | RG_LEFT;
    if (p.x > w.x_max) c = c | RG_RIGHT;
    if (p.y < w.y_min) c = c | RG_BOTTOM;
    if (p.y > w.y_max) c = c | RG_TOP;
    return c;
  endfunction

  // next edge operation for a segment, given what has been applied so far
  function automatic op_t next_op(input seg_t s, input window_t w);
    op_t  op;
    logic al, at, ab, br, bt, bb;
    logic ay_lo, ay_hi, ax_lo, ax_hi, by_lo, by_hi, bx_hi;
    al    = s.done[DN_AL];
    at    = s.done[DN_AT];
    ab    = s.done[DN_AB];
    br    = s.done[DN_BR];
    bt    = s.done[DN_BT];
    bb    = s.done[DN_BB];
    ay_lo = s.a.y < w.y_min;
    ay_hi = s.a.y > w.y_max;
    ax_lo = s.a.x < w.x_min;
    ax_hi = s.a.x > w.x_max;
    by_lo = s.b.y < w.y_min;
    by_hi = s.b.y > w.y_max;
    bx_hi = s.b.x > w.x_max;
    op    = OP_NONE;
    case (s.case_code)
      {RC_IN, RC_IN}: op = OP_NONE;
      {RC_IN, RC_R}: if (!br) op = OP_B_RIGHT;
      {RC_IN, RC_B}: if (!bb) op = OP_B_BOT;
      {RC_IN, RC_RB}: begin
        if (!br) op = OP_B_RIGHT;
        else if (!bb && by_lo) op = OP_B_BOT;
      end
      {RC_IN, RC_T}: if (!bt) op = OP_B_TOP;
      {RC_IN, RC_RT}: begin
        if (!br) op = OP_B_RIGHT;
        else if (!bt && by_hi) op = OP_B_TOP;
      end
      {RC_L, RC_IN}: if (!al) op = OP_A_LEFT;
      {RC_L, RC_R}: begin
        if (!al) op = OP_A_LEFT;
        else if (!br) op = OP_B_RIGHT;
      end
      {RC_L, RC_B}: begin
        if (!al) op = OP_A_LEFT;
        else if (ay_lo) op = OP_REJECT;
        else if (!bb) op = OP_B_BOT;
      end
      {RC_L, RC_RB}: begin
        if (!al) op = OP_A_LEFT;
        else if (ay_lo) op = OP_REJECT;
        else if (!bb) op = OP_B_BOT;
        else if (!br && bx_hi) op = OP_B_RIGHT;
      end
      {RC_L, RC_T}: begin
        if (!al) op = OP_A_LEFT;
        else if (ay_hi) op = OP_REJECT;
        else if (!bt) op = OP_B_TOP;
      end
      {RC_L, RC_RT}: begin
        if (!al) op = OP_A_LEFT;
        else if (ay_hi) op = OP_REJECT;
        else if (!bt) op = OP_B_TOP;
        else if (!br && bx_hi) op = OP_B_RIGHT;
      end
      {RC_B, RC_IN}: if (!ab) op = OP_A_BOT;
      {RC_B, RC_R}: begin
        if (!ab) op = OP_A_BOT;
        else if (ax_hi) op = OP_REJECT;
        else if (!br) op = OP_B_RIGHT;
      end
      {RC_B, RC_T}: begin
        if (!ab) op = OP_A_BOT;
        else if (!bt) op = OP_B_TOP;
      end
      {RC_B, RC_RT}: begin
        if (!ab) op = OP_A_BOT;
        else if (ax_hi) op = OP_REJECT;
        else if (!br) op = OP_B_RIGHT;
        else if (!bt && by_hi) op = OP_B_TOP;
      end
      {RC_LB, RC_IN}: begin
        if (!al) op = OP_A_LEFT;
        else if (!ab && ay_lo) op = OP_A_BOT;
      end
      {RC_LB, RC_R}: begin
        if (!ab) op = OP_A_BOT;
        else if (ax_hi) op = OP_REJECT;
        else if (!al && ax_lo) op = OP_A_LEFT;
        else if (!br) op = OP_B_RIGHT;
      end
      {RC_LB, RC_T}: begin
        if (!al) op = OP_A_LEFT;
        else if (ay_hi) op = OP_REJECT;
        else if (!ab && ay_lo) op = OP_A_BOT;
        else if (!bt) op = OP_B_TOP;
      end
      {RC_LB, RC_RT}: begin
        if (!al) op = OP_A_LEFT;
        else if (ay_hi) op = OP_REJECT;
        else if (!ab && ay_lo) op = OP_A_BOT;
        else if (ab && ax_hi) op = OP_REJECT;
        else if (!bt) op = OP_B_TOP;
        else if (!br && bx_hi) op = OP_B_RIGHT;
      end
      {RC_T, RC_IN}: if (!at) op = OP_A_TOP;
      {RC_T, RC_R}: begin
        if (!at) op = OP_A_TOP;
        else if (ax_hi) op = OP_REJECT;
        else if (!br) op = OP_B_RIGHT;
      end
      {RC_T, RC_B}: begin
        if (!at) op = OP_A_TOP;
        else if (!bb) op = OP_B_BOT;
      end
      {RC_T, RC_RB}: begin
        if (!at) op = OP_A_TOP;
        else if (ax_hi) op = OP_REJECT;
        else if (!br) op = OP_B_RIGHT;
        else if (!bb && by_lo) op = OP_B_BOT;
      end
      {RC_LT, RC_IN}: begin
        if (!al) op = OP_A_LEFT;
        else if (!at && ay_hi) op = OP_A_TOP;
      end
      {RC_LT, RC_R}: begin
        if (!at) op = OP_A_TOP;
        else if (ax_hi) op = OP_REJECT;
        else if (!al && ax_lo) op = OP_A_LEFT;
        else if (!br) op = OP_B_RIGHT;
      end
      {RC_LT, RC_B}: begin
        if (!al) op = OP_A_LEFT;
        else if (ay_lo) op = OP_REJECT;
        else if (!at && ay_hi) op = OP_A_TOP;
        else if (!bb) op = OP_B_BOT;
      end
      {RC_LT, RC_RB}: begin
        if (!al) op = OP_A_LEFT;
        else if (ay_lo) op = OP_REJECT;
        else if (!at && ay_hi) op = OP_A_TOP;
        else if (at && ax_hi) op = OP_REJECT;
        else if (!bb) op = OP_B_BOT;
        else if (!br && bx_hi) op = OP_B_RIGHT;
      end
      default: op = OP_REJECT;
    endcase
    return op;
  endfunction

endpackage

/* rtl/lswc_prep.sv */
// ---------------------------------------------------------------------------
// lswc_prep
// orders the endpoints by x and forms region codes and the case code
// ---------------------------------------------------------------------------
module lswc_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  lswc_pkg::window_t win,
  input  logic              in_valid,
  output logic              in_ready,
  input  lswc_pkg::point_t  in_a,
  input  lswc_pkg::point_t  in_b,
  output logic              out_valid,
  input  logic              out_ready,
  output lswc_pkg::seg_t    out_seg
);
  import lswc_pkg::*;

  logic   v1_r, v2_r;
  logic   en1, en2;
  point_t a_r, b_r, a_nxt, b_nxt;
  seg_t   seg_r, seg_nxt;
  logic [3:0] ca, cb;

  // stage enables, a bubble is always filled
  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // order endpoints, equal x keeps input order
  always_comb begin
    if (in_a.x > in_b.x) begin
      a_nxt = in_b;
      b_nxt = in_a;
    end else begin
      a_nxt = in_a;
      b_nxt = in_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  // region codes, trivial reject and empty window
  always_comb begin
    ca                = region_code(a_r, win);
    cb                = region_code(b_r, win);
    seg_nxt.a         = a_r;
    seg_nxt.b         = b_r;
    seg_nxt.case_code = {ca, cb};
    seg_nxt.done      = '0;
    seg_nxt.rej       = (win.x_min > win.x_max) || (win.y_min > win.y_max) || ((ca & cb) != 4'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      seg_r <= seg_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_seg   = seg_r;

endmodule

/* rtl/lswc_cut.sv */
// ---------------------------------------------------------------------------
// lswc_cut
// one clip step: picks the next edge, then intersects with a multiply and a
// pipelined restoring divide
// ---------------------------------------------------------------------------
module lswc_cut (
  input  logic              clk,
  input  logic              rst_n,
  input  lswc_pkg::window_t win,
  input  logic              in_valid,
  output logic              in_ready,
  input  lswc_pkg::seg_t    in_seg,
  output logic              out_valid,
  input  logic              out_ready,
  output lswc_pkg::seg_t    out_seg
);
  import lswc_pkg::*;

  typedef struct packed {
    seg_t   seg;
    op_t    op;
    coord_t kq;
    logic   neg;
    logic   dz;
  } side_t;

  // stage valids and enables
  logic v0_r, v1_r, v2_r, vw_r;
  logic en0, en1, en2, en_wb;
  logic dv_r   [DIV_STAGES];
  logic div_en [DIV_STAGES];

  // decision stage
  op_t    op_nxt, op0_r;
  seg_t   seg0_nxt, seg0_r;
  coord_t kp_nxt, kq_nxt, fp_nxt, fq_nxt, e_nxt;
  coord_t kp0_r, kq0_r, fp0_r, fq0_r, e0_r;

  // operand stage
  logic signed [COORD_W:0] kp_e, kq_e, fp_e, fq_e, e_e;
  logic signed [COORD_W:0] d_pos, d_neg, t_pos, t_neg, dq_pos, dq_alt, t_sel;
  logic [COORD_W-1:0]      d_mag, t_cl, q_mag;
  logic                    neg_d;
  side_t                   side1_nxt, side1_r;
  logic [COORD_W-1:0]      t1_r, d1_r, mag1_r;

  // multiply stage
  logic [2*COORD_W-1:0] prod_nxt, prod2_r;
  logic [COORD_W-1:0]   d2_r;
  side_t                side2_r;

  // divider stages
  side_t              dside_r [DIV_STAGES];
  logic [COORD_W-1:0] rem_r   [DIV_STAGES];
  logic [COORD_W-1:0] pq_r    [DIV_STAGES];
  logic [COORD_W-1:0] dd_r    [DIV_STAGES];

  // write-back stage
  side_t                   side_w;
  logic signed [COORD_W:0] wkq_e, wq_e, wsum;
  coord_t                  res;
  seg_t                    segw_nxt, segw_r;

  // enables, from the output back to the input
  always_comb begin
    en_wb                 = !vw_r || out_ready;
    div_en[DIV_STAGES-1]  = !dv_r[DIV_STAGES-1] || en_wb;
    for (int j = DIV_STAGES - 2; j >= 0; j--) begin
      div_en[j] = !dv_r[j] || div_en[j+1];
    end
    en2 = !v2_r || div_en[0];
    en1 = !v1_r || en2;
    en0 = !v0_r || en1;
  end

  assign in_ready = en0;

  // pick the edge and route anchor and outer coordinates
  always_comb begin
    seg0_nxt = in_seg;
    op_nxt   = OP_NONE;
    if (!in_seg.rej) op_nxt = next_op(in_seg, win);
    if (op_nxt == OP_REJECT) begin
      seg0_nxt.rej = 1'b1;
      op_nxt       = OP_NONE;
    end
    kp_nxt = in_seg.b.x;
    kq_nxt = in_seg.b.y;
    fp_nxt = in_seg.a.x;
    fq_nxt = in_seg.a.y;
    e_nxt  = win.x_min;
    case (op_nxt)
      OP_A_TOP, OP_A_BOT: begin
        kp_nxt = in_seg.b.y;
        kq_nxt = in_seg.b.x;
        fp_nxt = in_seg.a.y;
        fq_nxt = in_seg.a.x;
        e_nxt  = (op_nxt == OP_A_TOP) ? win.y_max : win.y_min;
      end
      OP_B_RIGHT: begin
        kp_nxt = in_seg.a.x;
        kq_nxt = in_seg.a.y;
        fp_nxt = in_seg.b.x;
        fq_nxt = in_seg.b.y;
        e_nxt  = win.x_max;
      end
      OP_B_TOP, OP_B_BOT: begin
        kp_nxt = in_seg.a.y;
        kq_nxt = in_seg.a.x;
        fp_nxt = in_seg.b.y;
        fq_nxt = in_seg.b.x;
        e_nxt  = (op_nxt == OP_B_TOP) ? win.y_max : win.y_min;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      seg0_r <= seg0_nxt;
      op0_r  <= op_nxt;
      kp0_r  <= kp_nxt;
      kq0_r  <= kq_nxt;
      fp0_r  <= fp_nxt;
      fq0_r  <= fq_nxt;
      e0_r   <= e_nxt;
    end
  end

  // spans, offset to the edge clamped to the span, magnitudes
  always_comb begin
    kp_e   = {kp0_r[COORD_W-1], kp0_r};
    kq_e   = {kq0_r[COORD_W-1], kq0_r};
    fp_e   = {fp0_r[COORD_W-1], fp0_r};
    fq_e   = {fq0_r[COORD_W-1], fq0_r};
    e_e    = {e0_r[COORD_W-1], e0_r};
    d_pos  = fp_e - kp_e;
    d_neg  = kp_e - fp_e;
    t_pos  = e_e - kp_e;
    t_neg  = kp_e - e_e;
    dq_pos = fq_e - kq_e;
    dq_alt = kq_e - fq_e;
    neg_d  = d_pos[COORD_W];
    d_mag  = neg_d ? d_neg[COORD_W-1:0] : d_pos[COORD_W-1:0];
    t_sel  = neg_d ? t_neg : t_pos;
    if (t_sel[COORD_W]) begin
      t_cl = '0;
    end else if (t_sel[COORD_W-1:0] > d_mag) begin
      t_cl = d_mag;
    end else begin
      t_cl = t_sel[COORD_W-1:0];
    end
    q_mag         = dq_pos[COORD_W] ? dq_alt[COORD_W-1:0] : dq_pos[COORD_W-1:0];
    side1_nxt.seg = seg0_r;
    side1_nxt.op  = op0_r;
    side1_nxt.kq  = kq0_r;
    side1_nxt.neg = dq_pos[COORD_W];
    side1_nxt.dz  = (d_pos == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v0_r) begin
      side1_r <= side1_nxt;
      t1_r    <= t_cl;
      d1_r    <= d_mag;
      mag1_r  <= q_mag;
    end
  end

  // offset times span of the moved coordinate
  assign prod_nxt = {{COORD_W{1'b0}}, t1_r} * {{COORD_W{1'b0}}, mag1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      side2_r <= side1_r;
      prod2_r <= prod_nxt;
      d2_r    <= d1_r;
    end
  end

  // restoring divide, a few quotient bits per stage; the high half of the
  // product is below the divisor, so the quotient fits one coordinate
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [COORD_W-1:0] rem_in, pq_in, dd_in, rem_nxt, pq_nxt;
    side_t              side_in;
    logic               v_in;

    if (j == 0) begin : g_first
      assign rem_in  = prod2_r[2*COORD_W-1:COORD_W];
      assign pq_in   = prod2_r[COORD_W-1:0];
      assign dd_in   = d2_r;
      assign side_in = side2_r;
      assign v_in    = v2_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign pq_in   = pq_r[j-1];
      assign dd_in   = dd_r[j-1];
      assign side_in = dside_r[j-1];
      assign v_in    = dv_r[j-1];
    end

    always_comb begin : p_steps
      logic [COORD_W:0]   trial;
      logic [COORD_W-1:0] rem_v, pq_v;
      rem_v = rem_in;
      pq_v  = pq_in;
      for (int k = 0; k < DIV_BITS; k++) begin
        trial = {rem_v, pq_v[COORD_W-1]};
        if (trial >= {1'b0, dd_in}) begin
          rem_v = COORD_W'(trial - {1'b0, dd_in});
          pq_v  = {pq_v[COORD_W-2:0], 1'b1};
        end else begin
          rem_v = trial[COORD_W-1:0];
          pq_v  = {pq_v[COORD_W-2:0], 1'b0};
        end
      end
      rem_nxt = rem_v;
      pq_nxt  = pq_v;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (div_en[j]) begin
        dv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (div_en[j] && v_in) begin
        rem_r[j]   <= rem_nxt;
        pq_r[j]    <= pq_nxt;
        dd_r[j]    <= dd_in;
        dside_r[j] <= side_in;
      end
    end
  end

  // move toward the outer endpoint and write the clipped point back
  always_comb begin
    side_w   = dside_r[DIV_STAGES-1];
    wkq_e    = {side_w.kq[COORD_W-1], side_w.kq};
    wq_e     = {1'b0, pq_r[DIV_STAGES-1]};
    wsum     = side_w.neg ? (wkq_e - wq_e) : (wkq_e + wq_e);
    res      = side_w.dz ? side_w.kq : wsum[COORD_W-1:0];
    segw_nxt = side_w.seg;
    case (side_w.op)
      OP_A_LEFT: begin
        segw_nxt.a.x         = win.x_min;
        segw_nxt.a.y         = res;
        segw_nxt.done[DN_AL] = 1'b1;
      end
      OP_A_TOP: begin
        segw_nxt.a.x         = res;
        segw_nxt.a.y         = win.y_max;
        segw_nxt.done[DN_AT] = 1'b1;
      end
      OP_A_BOT: begin
        segw_nxt.a.x         = res;
        segw_nxt.a.y         = win.y_min;
        segw_nxt.done[DN_AB] = 1'b1;
      end
      OP_B_RIGHT: begin
        segw_nxt.b.x         = win.x_max;
        segw_nxt.b.y         = res;
        segw_nxt.done[DN_BR] = 1'b1;
      end
      OP_B_TOP: begin
        segw_nxt.b.x         = res;
        segw_nxt.b.y         = win.y_max;
        segw_nxt.done[DN_BT] = 1'b1;
      end
      OP_B_BOT: begin
        segw_nxt.b.x         = res;
        segw_nxt.b.y         = win.y_min;
        segw_nxt.done[DN_BB] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= 1'b0;
    end else if (en_wb) begin
      vw_r <= dv_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_wb && dv_r[DIV_STAGES-1]) begin
      segw_r <= segw_nxt;
    end
  end

  assign out_valid = vw_r;
  assign out_seg   = segw_r;

endmodule

/* rtl/line_segment_window_clipper.sv */
// ---------------------------------------------------------------------------
// line_segment_window_clipper
// case-code fast clipping of line segments against a rectangular window
//
// in_*  : one segment per item, start/end points in signed Q16.16
// out_* : one result per segment, visible flag in tuser, clipped points in
//         tdata with the smaller-x endpoint first; all zero when not visible
// cfg_* : window edges x_min, y_min, x_max, y_max (index 0..3), write only
// Throughput is one item per clock. The pipeline has two preparation
// stages, four clip steps of 12 stages each (edge pick, operands, 32x32
// multiply, eight divider stages of four quotient bits, write-back) and the
// output register. Every stage holds its own valid bit, so bubbles close up
// and items keep entering while a result waits at the output; when the
// receiver stalls the pipeline fills and in_tready drops only once every
// stage holds an item. Synchronous reset empties the pipeline and sets the
// window to x and y from 0 up to the largest positive coordinate.
// ---------------------------------------------------------------------------
`include "line_segment_window_clipper_macros.svh"

module line_segment_window_clipper (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // clipped_left_x, clipped_left_y, clipped_right_x, clipped_right_y
  output logic [127:0] out_tdata,
  // visible
  output logic [0:0]   out_tuser
);
  import lswc_pkg::*;

  localparam int NUM_CUTS = 4;

  window_t win_r;
  point_t  in_a, in_b;
  seg_t    chain_seg [NUM_CUTS+1];
  logic    chain_v   [NUM_CUTS+1];
  logic    chain_rdy [NUM_CUTS+1];
  logic    out_en;
  logic    out_vld_r;
  logic [127:0] out_data_r, out_data_nxt;
  logic         out_vis_r;
  seg_t         last_seg;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.x_min <= 32'sd0;
      win_r.y_min <= 32'sd0;
      win_r.x_max <= 32'sh7fffffff;
      win_r.y_max <= 32'sh7fffffff;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_X_MIN: win_r.x_min <= cfg_wdata;
        CFG_Y_MIN: win_r.y_min <= cfg_wdata;
        CFG_X_MAX: win_r.x_max <= cfg_wdata;
        CFG_Y_MAX: win_r.y_max <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // unpack input item
  assign in_a.x = in_tdata[31:0];
  assign in_a.y = in_tdata[63:32];
  assign in_b.x = in_tdata[95:64];
  assign in_b.y = in_tdata[127:96];

  lswc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_a      (in_a),
    .in_b      (in_b),
    .out_valid (chain_v[0]),
    .out_ready (chain_rdy[0]),
    .out_seg   (chain_seg[0])
  );

  // clip steps in series
  for (genvar c = 0; c < NUM_CUTS; c++) begin : g_cut
    lswc_cut u_cut (
      .clk       (clk),
      .rst_n     (rst_n),
      .win       (win_r),
      .in_valid  (chain_v[c]),
      .in_ready  (chain_rdy[c]),
      .in_seg    (chain_seg[c]),
      .out_valid (chain_v[c+1]),
      .out_ready (chain_rdy[c+1]),
      .out_seg   (chain_seg[c+1])
    );
  end

  // output register, rejected segments give zero coordinates
  assign out_en              = !out_vld_r || out_tready;
  assign chain_rdy[NUM_CUTS] = out_en;
  assign last_seg            = chain_seg[NUM_CUTS];
  assign out_data_nxt        = last_seg.rej ? 128'b0 :
                               {last_seg.b.y, last_seg.b.x, last_seg.a.y, last_seg.a.x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= chain_v[NUM_CUTS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && chain_v[NUM_CUTS]) begin
      out_data_r <= out_data_nxt;
      out_vis_r  <= !last_seg.rej;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_vis_r;

  // checks
  `LSWC_ASSERT_IMP(a_invis_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == 128'b0, "invisible item has nonzero coordinates")
  `LSWC_ASSERT_IMP(a_full_only, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input blocked without an output stall")
  `LSWC_ASSERT_NEXT(a_cfg_xmax, clk, rst_n, cfg_wr_en && (cfg_index == CFG_X_MAX), win_r.x_max == $signed($past(cfg_wdata)), "x_max write not taken")

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// segment clipper testbench
// drives segments through the window clipper under random stalls, predicts
// each clipped result with a local case-code model and compares field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lswc_pkg::*;

  localparam int LATENCY = 51;

  typedef struct {
    logic           vis;
    logic [31:0]    lx, ly, rx, ry;
  } clip_res_t;

  typedef struct {
    logic [31:0] sx, sy, ex, ey;
    logic        chk;   // typed-in result present
    clip_res_t   res;
  } seg_row_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [0:0]   out_tuser;

  longint win_xmin, win_ymin, win_xmax, win_ymax;
  clip_res_t clip_q[$];
  int  fail_cnt;
  bit  sink_calm;
  int  sink_hold;

  line_segment_window_clipper u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // coordinate moved onto an edge, rounded toward the anchor
  function automatic longint edge_cut(longint kp, longint kq, longint op, longint oq,
                                      longint e);
    longint d, t, dq;
    longint unsigned mag, q;
    d = op - kp; t = e - kp; dq = oq - kq;
    if (d == 0) return kq;
    if (d < 0) begin d = -d; t = -t; end
    if (t < 0) t = 0;
    if (t > d) t = d;
    mag = (dq < 0) ? longint'(-dq) : longint'(dq);
    q = (longint'(t) * mag) / longint'(d);
    return (dq < 0) ? kq - longint'(q) : kq + longint'(q);
  endfunction

  function automatic logic [3:0] zone(longint x, longint y);
    logic [3:0] c;
    c = RC_IN;
    if (x < win_xmin) c |= RG_LEFT;
    if (x > win_xmax) c |= RG_RIGHT;
    if (y < win_ymin) c |= RG_BOTTOM;
    if (y > win_ymax) c |= RG_TOP;
    return c;
  endfunction

  function automatic clip_res_t clip_segment(logic [31:0] sx, logic [31:0] sy,
                                             logic [31:0] ex, logic [31:0] ey);
    clip_res_t r;
    longint ax, ay, bx, by, tx, ty;
    logic [3:0] ca, cb;
    logic ok;
    int steps;
    bit al, at, ab, br, bt, bb;
    op_t op;
    ax = longint'(signed'(sx)); ay = longint'(signed'(sy));
    bx = longint'(signed'(ex)); by = longint'(signed'(ey));
    if (ax > bx) begin
      tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty;
    end
    ok = 1'b0;
    {al, at, ab, br, bt, bb} = '0;
    if (win_xmin <= win_xmax && win_ymin <= win_ymax) begin
      ca = zone(ax, ay);
      cb = zone(bx, by);
      if ((ca & cb) == 0) begin
        ok = 1'b1;
        // walk the case table one edge step at a time
        for (steps = 0; steps < 8 && ok; steps++) begin
          op = OP_NONE;
          case ({ca, cb})
            {RC_IN, RC_IN}: ;
            {RC_IN, RC_R}: if (!br) op = OP_B_RIGHT;
            {RC_IN, RC_B}: if (!bb) op = OP_B_BOT;
            {RC_IN, RC_RB}: if (!br) op = OP_B_RIGHT;
              else if (!bb && by < win_ymin) op = OP_B_BOT;
            {RC_IN, RC_T}: if (!bt) op = OP_B_TOP;
            {RC_IN, RC_RT}: if (!br) op = OP_B_RIGHT;
              else if (!bt && by > win_ymax) op = OP_B_TOP;
            {RC_L, RC_IN}: if (!al) op = OP_A_LEFT;
            {RC_L, RC_R}: if (!al) op = OP_A_LEFT; else if (!br) op = OP_B_RIGHT;
            {RC_L, RC_B}: if (!al) op = OP_A_LEFT;
              else if (ay < win_ymin) op = OP_REJECT; else if (!bb) op = OP_B_BOT;
            {RC_L, RC_RB}: if (!al) op = OP_A_LEFT;
              else if (ay < win_ymin) op = OP_REJECT; else if (!bb) op = OP_B_BOT;
              else if (!br && bx > win_xmax) op = OP_B_RIGHT;
            {RC_L, RC_T}: if (!al) op = OP_A_LEFT;
              else if (ay > win_ymax) op = OP_REJECT; else if (!bt) op = OP_B_TOP;
            {RC_L, RC_RT}: if (!al) op = OP_A_LEFT;
              else if (ay > win_ymax) op = OP_REJECT; else if (!bt) op = OP_B_TOP;
              else if (!br && bx > win_xmax) op = OP_B_RIGHT;
            {RC_B, RC_IN}: if (!ab) op = OP_A_BOT;
            {RC_B, RC_R}: if (!ab) op = OP_A_BOT;
              else if (ax > win_xmax) op = OP_REJECT; else if (!br) op = OP_B_RIGHT;
            {RC_B, RC_T}: if (!ab) op = OP_A_BOT; else if (!bt) op = OP_B_TOP;
            {RC_B, RC_RT}: if (!ab) op = OP_A_BOT;
              else if (ax > win_xmax) op = OP_REJECT; else if (!br) op = OP_B_RIGHT;
              else if (!bt && by > win_ymax) op = OP_B_TOP;
            {RC_LB, RC_IN}: if (!al) op = OP_A_LEFT;
              else if (!ab && ay < win_ymin) op = OP_A_BOT;
            {RC_LB, RC_R}: if (!ab) op = OP_A_BOT;
              else if (ax > win_xmax) op = OP_REJECT;
              else if (!al && ax < win_xmin) op = OP_A_LEFT;
              else if (!br) op = OP_B_RIGHT;
            {RC_LB, RC_T}: if (!al) op = OP_A_LEFT;
              else if (ay > win_ymax) op = OP_REJECT;
              else if (!ab && ay < win_ymin) op = OP_A_BOT;
              else if (!bt) op = OP_B_TOP;
            {RC_LB, RC_RT}: if (!al) op = OP_A_LEFT;
              else if (ay > win_ymax) op = OP_REJECT;
              else if (!ab && ay < win_ymin) op = OP_A_BOT;
              else if (ab && ax > win_xmax) op = OP_REJECT;
              else if (!bt) op = OP_B_TOP;
              else if (!br && bx > win_xmax) op = OP_B_RIGHT;
            {RC_T, RC_IN}: if (!at) op = OP_A_TOP;
            {RC_T, RC_R}: if (!at) op = OP_A_TOP;
              else if (ax > win_xmax) op = OP_REJECT; else if (!br) op = OP_B_RIGHT;
            {RC_T, RC_B}: if (!at) op = OP_A_TOP; else if (!bb) op = OP_B_BOT;
            {RC_T, RC_RB}: if (!at) op = OP_A_TOP;
              else if (ax > win_xmax) op = OP_REJECT; else if (!br) op = OP_B_RIGHT;
              else if (!bb && by < win_ymin) op = OP_B_BOT;
            {RC_LT, RC_IN}: if (!al) op = OP_A_LEFT;
              else if (!at && ay > win_ymax) op = OP_A_TOP;
            {RC_LT, RC_R}: if (!at) op = OP_A_TOP;
              else if (ax > win_xmax) op = OP_REJECT;
              else if (!al && ax < win_xmin) op = OP_A_LEFT;
              else if (!br) op = OP_B_RIGHT;
            {RC_LT, RC_B}: if (!al) op = OP_A_LEFT;
              else if (ay < win_ymin) op = OP_REJECT;
              else if (!at && ay > win_ymax) op = OP_A_TOP;
              else if (!bb) op = OP_B_BOT;
            {RC_LT, RC_RB}: if (!al) op = OP_A_LEFT;
              else if (ay < win_ymin) op = OP_REJECT;
              else if (!at && ay > win_ymax) op = OP_A_TOP;
              else if (at && ax > win_xmax) op = OP_REJECT;
              else if (!bb) op = OP_B_BOT;
              else if (!br && bx > win_xmax) op = OP_B_RIGHT;
            default: op = OP_REJECT;
          endcase
          case (op)
            OP_A_LEFT:  begin ay = edge_cut(bx, by, ax, ay, win_xmin); ax = win_xmin; al = 1; end
            OP_A_TOP:   begin ax = edge_cut(by, bx, ay, ax, win_ymax); ay = win_ymax; at = 1; end
            OP_A_BOT:   begin ax = edge_cut(by, bx, ay, ax, win_ymin); ay = win_ymin; ab = 1; end
            OP_B_RIGHT: begin by = edge_cut(ax, ay, bx, by, win_xmax); bx = win_xmax; br = 1; end
            OP_B_TOP:   begin bx = edge_cut(ay, ax, by, bx, win_ymax); by = win_ymax; bt = 1; end
            OP_B_BOT:   begin bx = edge_cut(ay, ax, by, bx, win_ymin); by = win_ymin; bb = 1; end
            OP_REJECT:  ok = 1'b0;
            default:    steps = 8;
          endcase
        end
      end
    end
    r.vis = ok;
    r.lx = ok ? ax[31:0] : '0;
    r.ly = ok ? ay[31:0] : '0;
    r.rx = ok ? bx[31:0] : '0;
    r.ry = ok ? by[31:0] : '0;
    return r;
  endfunction

  task automatic write_window(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_X_MIN: win_xmin = longint'(signed'(val));
      CFG_Y_MIN: win_ymin = longint'(signed'(val));
      CFG_X_MAX: win_xmax = longint'(signed'(val));
      default:   win_ymax = longint'(signed'(val));
    endcase
  endtask

  task automatic set_window(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                            logic [31:0] y1);
    write_window(CFG_X_MIN, x0);
    write_window(CFG_Y_MIN, y0);
    write_window(CFG_X_MAX, x1);
    write_window(CFG_Y_MAX, y1);
  endtask

  task automatic wait_drained();
    while (clip_q.size() != 0) @(negedge clk);
  endtask

  // offer one segment, optional gap first; valid stays high across items
  task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                              logic [31:0] ey, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ey, ex, sy, sx};
    clip_q.push_back(clip_segment(sx, sy, ex, ey));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // random coordinate, mostly near the window, sometimes at the extremes
  function automatic logic [31:0] rand_coord(longint lo, longint hi);
    longint span;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: begin
        span = hi - lo;
        if (span < 16) span = 16;
        return 32'(lo - span / 2 + longint'($urandom) % (span * 2));
      end
    endcase
  endfunction

  // result side: stalls in bursts, checks against oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (clip_q.size() == 0) begin
        $error("result with no segment outstanding");
        fail_cnt++;
      end else begin
        clip_res_t e;
        e = clip_q.pop_front();
        if (out_tuser[0] !== e.vis) begin
          $error("visible exp %0d got %0d", e.vis, out_tuser[0]); fail_cnt++;
        end
        if (out_tdata[31:0] !== e.lx) begin
          $error("clipped_left_x exp %h got %h", e.lx, out_tdata[31:0]); fail_cnt++;
        end
        if (out_tdata[63:32] !== e.ly) begin
          $error("clipped_left_y exp %h got %h", e.ly, out_tdata[63:32]); fail_cnt++;
        end
        if (out_tdata[95:64] !== e.rx) begin
          $error("clipped_right_x exp %h got %h", e.rx, out_tdata[95:64]); fail_cnt++;
        end
        if (out_tdata[127:96] !== e.ry) begin
          $error("clipped_right_y exp %h got %h", e.ry, out_tdata[127:96]); fail_cnt++;
        end
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        sink_hold--;
      end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  seg_row_t rows[$];

  task automatic add_row(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                         logic [31:0] ey, bit chk = 0, logic vis = 0);
    seg_row_t r;
    r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.chk = chk;
    r.res.vis = vis;
    r.res.lx = '0; r.res.ly = '0; r.res.rx = '0; r.res.ry = '0;
    rows.push_back(r);
  endtask

  initial begin
    int n, k;
    logic [31:0] w0, w1, w2, w3;
    clip_res_t p;
    fail_cnt  = 0;
    sink_calm = 1'b0;
    sink_hold = 0;
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    win_xmin = 0; win_ymin = 0; win_xmax = 32'h7fff_ffff; win_ymax = 32'h7fff_ffff;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // after reset: window is the positive quadrant
    add_row(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    add_row(32'hffff_0000, 32'hfff0_0000, 32'hfffe_0000, 32'h0005_0000, 1, 1'b0);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 1'b0);
    foreach (rows[i]) begin
      p = clip_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey);
      if (rows[i].chk && p.vis !== rows[i].res.vis) begin
        $error("visible table exp %0d pred %0d", rows[i].res.vis, p.vis); fail_cnt++;
      end
      send_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey, 0);
    end
    in_tvalid <= 1'b0;
    wait_drained();
    rows.delete();

    // small window 10..20 in both axes; one row per case family
    set_window(32'h000a_0000, 32'h000a_0000, 32'h0014_0000, 32'h0014_0000);
    add_row(32'h000c_0000, 32'h000c_0000, 32'h0018_0000, 32'h0008_0000); // in to rb
    add_row(32'h0008_0000, 32'h000c_0000, 32'h0018_0000, 32'h000f_0000); // l to r
    add_row(32'h0005_0000, 32'h0005_0000, 32'h0019_0000, 32'h0019_0000); // lb to rt
    add_row(32'h0005_0000, 32'h0019_0000, 32'h0019_0000, 32'h0005_0000); // lt to rb
    add_row(32'h0008_0000, 32'h0001_0000, 32'h0018_0000, 32'h0003_0000); // lb to rb reject
    add_row(32'h0001_0000, 32'h0008_0000, 32'h000c_0000, 32'h0000_0000); // lb corner miss
    add_row(32'h000c_0000, 32'h0005_0000, 32'h000e_0000, 32'h0019_0000); // b to t
    add_row(32'h000c_0000, 32'h0019_0000, 32'h0016_0000, 32'h000e_0000); // t to r
    add_row(32'h0000_0000, 32'h0013_0000, 32'h0015_0000, 32'h0032_0000); // l to rt miss
    add_row(32'h0013_0000, 32'h0009_0000, 32'h0030_0000, 32'h0015_0000); // b to rt, x past
    add_row(32'h000f_0000, 32'h000f_0000, 32'h000c_0000, 32'h000d_0000); // swapped inside
    add_row(32'h000f_0000, 32'h0000_0000, 32'h000f_0000, 32'h0030_0000); // vertical
    add_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff); // extremes
    add_row(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    foreach (rows[i]) send_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey, 0);
    in_tvalid <= 1'b0;
    wait_drained();
    rows.delete();

    // empty window: nothing visible
    set_window(32'h0014_0000, 32'h0, 32'h000a_0000, 32'h0014_0000);
    add_row(32'h000c_0000, 32'h000c_0000, 32'h000d_0000, 32'h000d_0000, 1, 1'b0);
    foreach (rows[i]) send_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey, 0);
    in_tvalid <= 1'b0;
    wait_drained();

    // full range window
    set_window(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_segment(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    in_tvalid <= 1'b0;
    wait_drained();

    // random phases, new window each, sender gaps and a long receiver hold
    for (k = 0; k < 6; k++) begin
      w0 = 32'(longint'($urandom_range(0, 400)) * 65536 - 200 * 65536 + $urandom_range(0, 65535));
      w1 = 32'(longint'($urandom_range(0, 400)) * 65536 - 200 * 65536 + $urandom_range(0, 65535));
      w2 = 32'(longint'(signed'(w0)) + $urandom_range(1, 300 * 65536));
      w3 = 32'(longint'(signed'(w1)) + $urandom_range(1, 300 * 65536));
      if (k == 5) begin
        w2 = w0;
        w3 = w1;
      end
      set_window(w0, w1, w2, w3);
      if (k == 1) sink_hold = 300;
      if (k == 5) sink_calm = 1'b1;
      for (n = 0; n < 155; n++)
        send_segment(rand_coord(win_xmin, win_xmax), rand_coord(win_ymin, win_ymax),
                     rand_coord(win_xmin, win_xmax), rand_coord(win_ymin, win_ymax),
                     !sink_calm);
      in_tvalid <= 1'b0;
      wait_drained();
      repeat (LATENCY + 4) @(negedge clk);
    end

    if (fail_cnt == 0 && clip_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
